// ===== rtl/core/dpn_pkg.sv =====
package dpn_pkg;

   localparam int SINE_ADDR_BITS_DEF = 10;
   localparam int SAMPLE_BITS_DEF    = 16;

   localparam logic [15:0] PROP_GAIN_RST  = 16'd17479;
   localparam logic [15:0] INTEG_GAIN_RST = 16'd1167;
   localparam logic [15:0] NCO_GAIN_RST   = 16'd10430;
   localparam logic [31:0] PHASE_STEP_RST = 32'd429496730;

   // polynomial for sin(pi/2*u), u in q30
   localparam logic [63:0] POLY_C1 = 64'd1686629713;
   localparam logic [63:0] POLY_C3 = 64'd693598668;
   localparam logic [63:0] POLY_C5 = 64'd85569306;
   localparam logic [63:0] POLY_C7 = 64'd5026995;
   localparam logic [63:0] POLY_C9 = 64'd172272;
   localparam logic [63:0] Q30_ONE = 64'd1073741824;

   typedef enum logic [1:0] {
      CSR_PROP_GAIN  = 2'd0,
      CSR_INTEG_GAIN = 2'd1,
      CSR_NCO_GAIN   = 2'd2,
      CSR_PHASE_STEP = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic accept;
      logic gain;
      logic filt;
      logic nco;
      logic commit;
   } dpn_cmd_type;

   // saturate a 25-bit sum to 24 bits
   function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
      logic signed [23:0] r;
      if (v[24] != v[23]) begin
         r = v[24] ? 24'sh800000 : 24'sh7fffff;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

   // table entry for a full-turn table of 2^ab entries
   function automatic logic signed [15:0] sine_entry(input int unsigned addr,
                                                     input int unsigned ab);
      logic [31:0] x;
      logic [1:0]  quad;
      logic [63:0] u;
      logic [63:0] u2;
      logic [63:0] p;
      logic [63:0] r;
      logic [15:0] m;
      x    = 32'(addr) << (32 - ab);
      quad = x[31:30];
      u    = {34'd0, x[29:0]};
      if (quad[0]) begin
         u = Q30_ONE - u;
      end
      u2 = (u * u) >> 30;
      p  = POLY_C9;
      p  = POLY_C7 - ((u2 * p) >> 30);
      p  = POLY_C5 - ((u2 * p) >> 30);
      p  = POLY_C3 - ((u2 * p) >> 30);
      p  = POLY_C1 - ((u2 * p) >> 30);
      r  = (u * p) >> 30;
      r  = (r + 64'd16384) >> 15;
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      m = r[15:0];
      return quad[1] ? -m : m;
   endfunction

endpackage

// ===== rtl/core/dpn_sine_rom.sv =====
module dpn_sine_rom import dpn_pkg::*; #(
   parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [SINE_ADDR_BITS-1:0] rd_addr,
   output logic signed [15:0]        sine_ff,
   output logic signed [15:0]        cos_ff
);

   localparam int DEPTH = 2 ** SINE_ADDR_BITS;
   localparam logic [SINE_ADDR_BITS-1:0] QUARTER = SINE_ADDR_BITS'(DEPTH / 4);

   logic signed [15:0]        rom [DEPTH];
   logic [SINE_ADDR_BITS-1:0] cos_addr;

   for (genvar i = 0; i < DEPTH; i++) begin : g_rom
      assign rom[i] = sine_entry(i, SINE_ADDR_BITS);
   end

   // cosine sits a quarter turn ahead
   assign cos_addr = rd_addr + QUARTER;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         sine_ff <= rom[rd_addr];
         cos_ff  <= rom[cos_addr];
      end
   end

endmodule

// ===== rtl/core/dpn_ctrl.sv =====
module dpn_ctrl import dpn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output dpn_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GAIN,
      ST_FILT,
      ST_NCO,
      ST_PHASE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;
   logic      accept;
   logic      commit;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == ST_PHASE) && out_free;
   assign req_ready = (state_ff == ST_IDLE) || commit;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   assign cmd.accept = accept;
   assign cmd.gain   = (state_ff == ST_GAIN);
   assign cmd.filt   = (state_ff == ST_FILT);
   assign cmd.nco    = (state_ff == ST_NCO);
   assign cmd.commit = commit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE:  if (accept) state_ff <= ST_GAIN;
            ST_GAIN:  state_ff <= ST_FILT;
            ST_FILT:  state_ff <= ST_NCO;
            ST_NCO:   state_ff <= ST_PHASE;
            ST_PHASE: if (commit) state_ff <= accept ? ST_GAIN : ST_IDLE;
            default:  state_ff <= ST_IDLE;
         endcase
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GAIN || state_ff == ST_FILT || state_ff == ST_NCO) |-> !req_ready)
      else $error("sample taken mid computation");

   a_result_from_phase: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_PHASE)
      else $error("result raised outside commit step");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_GAIN)
      else $error("accepted sample not started");

   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PHASE && !out_free) |=> state_ff == ST_PHASE && rsp_valid_ff)
      else $error("commit step left while result register full");

endmodule

// ===== rtl/core/dpn_datapath.sv =====
module dpn_datapath import dpn_pkg::*; #(
   parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF,
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dpn_cmd_type                   cmd,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          csr_write_en,
   input  logic [1:0]                    csr_index,
   input  logic [31:0]                   csr_wdata,
   output logic signed [15:0]            rsp_cos_value,
   output logic signed [15:0]            rsp_neg_sine_value,
   output logic signed [23:0]            rsp_filter_value,
   output logic [31:0]                   rsp_phase_value
);

   localparam int SHR = (SAMPLE_BITS >= 16) ? SAMPLE_BITS - 16 : 0;
   localparam int SHL = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;

   logic [15:0] prop_gain_ff;
   logic [15:0] integ_gain_ff;
   logic [15:0] nco_gain_ff;
   logic [31:0] phase_step_ff;

   logic [31:0]        nom_ff;
   logic [31:0]        offset_ff;
   logic signed [23:0] integ_ff;
   logic signed [15:0] local_sine_ff;

   logic signed [17:0] err_ff;
   logic signed [18:0] ip_ff;
   logic signed [18:0] pp_ff;
   logic signed [23:0] filt_ff;
   logic [31:0]        delta_ff;
   logic [31:0]        angle_ff;

   logic signed [15:0] rsp_cos_ff;
   logic signed [15:0] rsp_neg_sine_ff;
   logic signed [23:0] rsp_filter_ff;
   logic [31:0]        rsp_phase_ff;

   logic signed [SAMPLE_BITS+15:0] samp_wide;
   logic signed [SAMPLE_BITS+15:0] samp_shift;
   logic signed [15:0]             s15;
   logic signed [31:0]             err_prod;
   logic signed [34:0]             ip_prod;
   logic signed [34:0]             pp_prod;
   logic signed [24:0]             integ_sum;
   logic signed [23:0]             integ_in;
   logic signed [24:0]             filt_sum;
   logic signed [23:0]             filt_in;
   logic signed [40:0]             nco_prod;
   logic [31:0]                    nom_in;
   logic [31:0]                    offset_in;
   logic signed [15:0]             sine_rd;
   logic signed [15:0]             cos_rd;

   // bring the sample to q1.15
   assign samp_wide  = (SAMPLE_BITS + 16)'(req_sample);
   assign samp_shift = (samp_wide <<< SHL) >>> SHR;
   assign s15        = samp_shift[15:0];

   assign err_prod  = s15 * local_sine_ff;
   assign ip_prod   = err_ff * $signed({1'b0, integ_gain_ff});
   assign pp_prod   = err_ff * $signed({1'b0, prop_gain_ff});
   assign integ_sum = 25'(integ_ff) + 25'(ip_ff);
   assign integ_in  = sat24(integ_sum);
   assign filt_sum  = 25'(pp_ff) + 25'(integ_in);
   assign filt_in   = sat24(filt_sum);
   assign nco_prod  = filt_ff * $signed({1'b0, nco_gain_ff});
   assign nom_in    = nom_ff + phase_step_ff;
   assign offset_in = offset_ff + delta_ff;

   dpn_sine_rom #(
      .SINE_ADDR_BITS(SINE_ADDR_BITS)
   ) u_rom (
      .clock   (clock),
      .rd_en   (cmd.filt),
      .rd_addr (angle_ff[31 -: SINE_ADDR_BITS]),
      .sine_ff (sine_rd),
      .cos_ff  (cos_rd)
   );

   // loop state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= PROP_GAIN_RST;
         integ_gain_ff <= INTEG_GAIN_RST;
         nco_gain_ff   <= NCO_GAIN_RST;
         phase_step_ff <= PHASE_STEP_RST;
         nom_ff        <= '0;
         offset_ff     <= '0;
         integ_ff      <= '0;
         local_sine_ff <= '0;
      end else begin
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_PROP_GAIN:  prop_gain_ff  <= csr_wdata[15:0];
               CSR_INTEG_GAIN: integ_gain_ff <= csr_wdata[15:0];
               CSR_NCO_GAIN:   nco_gain_ff   <= csr_wdata[15:0];
               CSR_PHASE_STEP: phase_step_ff <= csr_wdata;
               default:        ;
            endcase
         end
         if (cmd.gain)   nom_ff        <= nom_in;
         if (cmd.filt)   integ_ff      <= integ_in;
         if (cmd.nco)    local_sine_ff <= -sine_rd;
         if (cmd.commit) offset_ff     <= offset_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      if (cmd.accept) err_ff <= err_prod[31:14];
      if (cmd.gain) begin
         ip_ff    <= ip_prod[34:16];
         pp_ff    <= pp_prod[34:16];
         angle_ff <= nom_in + offset_ff;
      end
      if (cmd.filt) filt_ff  <= filt_in;
      if (cmd.nco)  delta_ff <= nco_prod[31:0];
      if (cmd.commit) begin
         rsp_cos_ff      <= cos_rd;
         rsp_neg_sine_ff <= local_sine_ff;
         rsp_filter_ff   <= filt_ff;
         rsp_phase_ff    <= offset_in;
      end
   end

   assign rsp_cos_value      = rsp_cos_ff;
   assign rsp_neg_sine_value = rsp_neg_sine_ff;
   assign rsp_filter_value   = rsp_filter_ff;
   assign rsp_phase_value    = rsp_phase_ff;

endmodule

// ===== rtl/core/digital_pll_pi_nco.sv =====
// channel  | handshake            | payload
// req      | req_valid/req_ready  | req_sample
// rsp      | rsp_valid/rsp_ready  | rsp_cos_value, rsp_neg_sine_value,
//          |                      | rsp_filter_value, rsp_phase_value
// csr      | csr_write_en         | csr_index, csr_wdata
//
// each sample runs this chain of steps in order
// error multiply, gain multiplies, filter adds, nco multiply, phase commit
// the next sample transfers in the commit cycle of the previous one
// reset is synchronous, no clearing pass
// a result held in the output register stalls the commit step and req_ready
module digital_pll_pi_nco import dpn_pkg::*; #(
   parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF,
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [15:0]            rsp_cos_value,
   output logic signed [15:0]            rsp_neg_sine_value,
   output logic signed [23:0]            rsp_filter_value,
   output logic [31:0]                   rsp_phase_value,
   input  logic                          csr_write_en,
   input  logic [1:0]                    csr_index,
   input  logic [31:0]                   csr_wdata
);

   // step commands from the sequencer
   dpn_cmd_type cmd;

   // sequencer: one sample at a time, output register decoupled
   dpn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // phase detector, pi filter, nco and sine table
   dpn_datapath #(
      .SINE_ADDR_BITS(SINE_ADDR_BITS),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_sample         (req_sample),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_cos_value      (rsp_cos_value),
      .rsp_neg_sine_value (rsp_neg_sine_value),
      .rsp_filter_value   (rsp_filter_value),
      .rsp_phase_value    (rsp_phase_value)
   );

endmodule
